[rtl/bvs_pkg.sv]
// Shared types and constants for the bounded unique value stack.
`default_nettype none
package bvs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 5;
  localparam int LIM_W     = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LIM_W-1:0] MAX_RESET = 5'd10;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_TOP  = 2'd2;

  localparam logic REG_MAX_ENTRIES = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_DUP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TOP
  } state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    status_t                 status;
    logic                    now_empty;
    logic [CNT_W-1:0]        entry_count;
  } out_word_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

[rtl/bvs_mem.sv]
// Entry storage: one port, write or registered read per cycle.
`default_nettype none
module bvs_mem #(
  parameter int DEPTH = bvs_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                              clk,
  input  bvs_pkg::mem_ctl_t                ctl,
  input  wire  [AW-1:0]                    addr,
  input  wire  [bvs_pkg::VAL_W-1:0]        wdata,
  output logic [bvs_pkg::VAL_W-1:0]        rdata
);

  logic [bvs_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[rtl/bvs_ctrl.sv]
// Sequencer: scans stored entries with one comparator, drives memory and results.
`default_nettype none
module bvs_ctrl #(
  parameter int DEPTH = bvs_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              accept,
  input  bvs_pkg::in_word_t                in_word,
  input  wire  [bvs_pkg::LIM_W-1:0]        max_entries,
  output logic                             busy,
  output bvs_pkg::mem_ctl_t                mem_ctl,
  output logic [AW-1:0]                    mem_addr,
  output logic [bvs_pkg::VAL_W-1:0]        mem_wdata,
  input  wire  [bvs_pkg::VAL_W-1:0]        mem_rdata,
  output logic                             res_valid,
  output bvs_pkg::out_word_t               res_word
);

  localparam int CW = bvs_pkg::CNT_W;

  bvs_pkg::state_t           state_r, state_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [bvs_pkg::VAL_W-1:0] val_r, val_nxt;
  logic                      full;
  logic                      hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bvs_pkg::ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
    val_r <= val_nxt;
  end

  assign full = (count_r >= max_entries) ||
                ({{(32-CW){1'b0}}, count_r} >= 32'(DEPTH));
  assign hit  = (mem_rdata == val_r);
  assign busy = (state_r != bvs_pkg::ST_IDLE);

  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    count_nxt          = count_r;
    val_nxt            = val_r;
    mem_ctl            = '0;
    mem_addr           = '0;
    mem_wdata          = val_r;
    res_valid          = 1'b0;
    res_word.top_value = '0;
    res_word.status    = bvs_pkg::STAT_OK;
    case (state_r)
      bvs_pkg::ST_IDLE: begin
        if (accept) begin
          val_nxt = in_word.push_value;
          case (in_word.opcode)
            bvs_pkg::OP_PUSH: begin
              if (full) begin
                res_valid       = 1'b1;
                res_word.status = bvs_pkg::STAT_FULL;
              end else if (count_r == '0) begin
                mem_ctl.wr_en = 1'b1;
                mem_wdata     = in_word.push_value;
                count_nxt     = CW'(1);
                res_valid     = 1'b1;
              end else begin
                mem_ctl.rd_en = 1'b1;
                idx_nxt       = '0;
                state_nxt     = bvs_pkg::ST_SCAN;
              end
            end
            bvs_pkg::OP_POP: begin
              res_valid = 1'b1;
              if (count_r == '0) begin
                res_word.status = bvs_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            bvs_pkg::OP_TOP: begin
              if (count_r == '0) begin
                res_valid       = 1'b1;
                res_word.status = bvs_pkg::STAT_EMPTY;
              end else begin
                mem_ctl.rd_en = 1'b1;
                mem_addr      = AW'(count_r - CW'(1));
                state_nxt     = bvs_pkg::ST_TOP;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      bvs_pkg::ST_SCAN: begin
        if (hit) begin
          res_valid       = 1'b1;
          res_word.status = bvs_pkg::STAT_DUP;
          state_nxt       = bvs_pkg::ST_IDLE;
        end else if (idx_r == count_r - CW'(1)) begin
          mem_ctl.wr_en = 1'b1;
          mem_addr      = AW'(count_r);
          count_nxt     = count_r + CW'(1);
          res_valid     = 1'b1;
          state_nxt     = bvs_pkg::ST_IDLE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_addr      = AW'(idx_r + CW'(1));
          idx_nxt       = idx_r + CW'(1);
        end
      end
      bvs_pkg::ST_TOP: begin
        res_valid          = 1'b1;
        res_word.top_value = mem_rdata;
        state_nxt          = bvs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bvs_pkg::ST_IDLE;
      end
    endcase
    res_word.entry_count = count_nxt;
    res_word.now_empty   = (count_nxt == '0);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-CW){1'b0}}, count_r} <= 32'(DEPTH))
    else $error("entry count above depth");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bvs_pkg::ST_SCAN |-> idx_r < count_r)
    else $error("scan index past stored entries");

  a_top_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bvs_pkg::ST_TOP |-> count_r != '0)
    else $error("top read on empty stack");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |=> count_r == $past(count_r) + CW'(1))
    else $error("store write without count increment");

  a_res_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (busy || accept))
    else $error("result word without a request");

endmodule
`default_nettype wire

[rtl/bounded_unique_value_stack_core.sv]
// Top level: bounded unique value stack with APB config and result register.
//
//   channel   ports                                   handshake
//   input     start, busy, in_word                    start && !busy
//   result    out_valid, out_word                     out_valid, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//             prdata, pready
//
// Pop and opcode 3 finish when accepted, busy stays low. Top read waits in ST_TOP
// for the memory read. Push of a new value scans the stored entries, one compare
// per entry through the single memory read port; full or duplicate ends it early.
// Result word appears on the cycle after the request finishes.
// rst_n (sync) empties the stack and sets max_entries to 10; store is not cleared.
// Results cannot be stalled.
`default_nettype none
module bounded_unique_value_stack_core #(
  parameter int DEPTH = bvs_pkg::DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  bvs_pkg::in_word_t                in_word,
  output logic                             out_valid,
  output bvs_pkg::out_word_t               out_word,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [bvs_pkg::PADDR_W-1:0]      paddr,
  input  wire  [bvs_pkg::PDATA_W-1:0]      pwdata,
  output logic [bvs_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int AW = $clog2(DEPTH);

  logic [bvs_pkg::LIM_W-1:0] max_r, max_nxt;
  logic                      out_valid_r;
  bvs_pkg::out_word_t        out_word_r;
  logic                      accept;
  logic                      res_valid;
  bvs_pkg::out_word_t        res_word;
  bvs_pkg::mem_ctl_t         mem_ctl;
  logic [AW-1:0]             mem_addr;
  logic [bvs_pkg::VAL_W-1:0] mem_wdata;
  logic [bvs_pkg::VAL_W-1:0] mem_rdata;
  logic                      reg_sel;

  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign reg_sel = (paddr[bvs_pkg::PADDR_W-1] == bvs_pkg::REG_MAX_ENTRIES);

  always_comb begin
    max_nxt = max_r;
    if (psel && penable && pwrite && reg_sel) begin
      max_nxt = pwdata[bvs_pkg::LIM_W-1:0];
    end
    prdata = reg_sel ? {{(bvs_pkg::PDATA_W-bvs_pkg::LIM_W){1'b0}}, max_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= bvs_pkg::MAX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      max_r       <= max_nxt;
      out_valid_r <= res_valid;
    end
    if (res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  bvs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_word     (in_word),
    .max_entries (max_r),
    .busy        (busy),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_word    (res_word)
  );

  bvs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

[tb/tb_bounded_unique_value_stack_core.sv]
// Testbench for the bounded unique value stack: directed and random requests checked per word.
`default_nettype none
module tb_bounded_unique_value_stack_core;
  import bvs_pkg::*;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [PADDR_W-1:0] MAX_ENTRIES_ADDR = {REG_MAX_ENTRIES, 2'b00};
  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_valid;
  out_word_t out_word;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  bounded_unique_value_stack_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_word(out_word),
    .psel(cfg_psel),
    .penable(cfg_penable),
    .pwrite(cfg_pwrite),
    .paddr(cfg_paddr),
    .pwdata(cfg_pwdata),
    .prdata(cfg_prdata),
    .pready(cfg_pready)
  );

  // shadow of the block's state
  logic [VAL_W-1:0] shadow_stack [STACK_DEPTH];
  logic [CNT_W-1:0] shadow_count;
  logic [LIM_W-1:0] shadow_max;

  out_word_t expected_words[$];
  int mismatches;
  int words_sent;
  int words_checked;
  int limit_writes;
  int cycle_count;
  bit gaps_on;

  always #10 clk = ~clk;

  function automatic out_word_t predict_stack_op(in_word_t w);
    out_word_t r;
    logic [CNT_W-1:0] lim;
    bit dup;
    int i;
    lim = (shadow_max > STACK_DEPTH) ? CNT_W'(STACK_DEPTH) : shadow_max;
    r.top_value = '0;
    r.status = STAT_OK;
    case (w.opcode)
      OP_PUSH: begin
        if (shadow_count >= lim) begin
          r.status = STAT_FULL;
        end else begin
          dup = 1'b0;
          for (i = 0; i < shadow_count; i++)
            if (shadow_stack[i] == w.push_value) dup = 1'b1;
          if (dup) begin
            r.status = STAT_DUP;
          end else begin
            shadow_stack[shadow_count] = w.push_value;
            shadow_count++;
          end
        end
      end
      OP_POP: begin
        if (shadow_count == 0) r.status = STAT_EMPTY;
        else shadow_count--;
      end
      OP_TOP: begin
        if (shadow_count == 0) r.status = STAT_EMPTY;
        else r.top_value = shadow_stack[shadow_count-1];
      end
      default: ;
    endcase
    r.now_empty = (shadow_count == 0);
    r.entry_count = shadow_count;
    return r;
  endfunction

  function automatic in_word_t req(logic [1:0] op, logic [VAL_W-1:0] v);
    in_word_t w;
    w.opcode = op;
    w.push_value = v;
    return w;
  endfunction

  // biased toward held values and a small pool so duplicates are common
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25 && shadow_count > 0)
      return shadow_stack[$urandom_range(0, shadow_count - 1)];
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    if (r < 55) return VAL_W'($signed($urandom_range(0, 15)) - 8);
    return $urandom;
  endfunction

  task automatic send_word(in_word_t w);
    in_word <= w;
    start <= 1'b1;
    do begin
      @(negedge clk);
      @(posedge clk);
    end while (busy);
    expected_words.push_back(predict_stack_op(w));
    words_sent++;
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 21) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [PDATA_W-1:0] d,
                            output logic [PDATA_W-1:0] rd);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= MAX_ENTRIES_ADDR;
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_max_entries(logic [LIM_W-1:0] lim, logic [PDATA_W-LIM_W-1:0] junk);
    logic [PDATA_W-1:0] rd;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_access(1'b1, {junk, lim}, rd);
    shadow_max = lim;
    limit_writes++;
    @(posedge clk);
    cfg_access(1'b0, '0, rd);
    if (rd[LIM_W-1:0] !== lim) begin
      $error("max_entries readback: expected %0d, actual %0d", lim, rd[LIM_W-1:0]);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with no request pending: %h", out_word);
        mismatches++;
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        if (out_word.top_value !== exp_w.top_value) begin
          $error("top_value: expected %0d, actual %0d", exp_w.top_value, out_word.top_value);
          mismatches++;
        end
        if (out_word.status !== exp_w.status) begin
          $error("status: expected %0d, actual %0d", exp_w.status, out_word.status);
          mismatches++;
        end
        if (out_word.now_empty !== exp_w.now_empty) begin
          $error("now_empty: expected %0d, actual %0d", exp_w.now_empty, out_word.now_empty);
          mismatches++;
        end
        if (out_word.entry_count !== exp_w.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 exp_w.entry_count, out_word.entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_empty_and_extremes();
    send_word(req(OP_TOP, 32'h1234_5678));
    send_word(req(OP_POP, 32'hffff_ffff));
    send_word(req(OP_NOP, 32'h0));
    send_word(req(OP_PUSH, 32'h8000_0000));
    send_word(req(OP_PUSH, 32'h7fff_ffff));
    send_word(req(OP_PUSH, 32'hffff_ffff));
    send_word(req(OP_PUSH, 32'h0));
    send_word(req(OP_PUSH, 32'h7fff_ffff));
    send_word(req(OP_PUSH, 32'h8000_0000));
    send_word(req(OP_TOP, 32'h5555_5555));
    send_word(req(OP_NOP, 32'haaaa_aaaa));
    send_word(req(OP_POP, 32'h0));
    send_word(req(OP_TOP, 32'h0));
    repeat (3) send_word(req(OP_POP, 32'h0));
    send_word(req(OP_POP, 32'h0));
    send_word(req(OP_TOP, 32'h0));
  endtask

  // full check wins over duplicate; zero limit refuses every push
  task automatic test_limit_edges();
    set_max_entries(5'd1, '0);
    send_word(req(OP_PUSH, 32'h0000_002a));
    send_word(req(OP_PUSH, 32'h0000_002b));
    send_word(req(OP_PUSH, 32'h0000_002a));
    send_word(req(OP_POP, 32'h0));
    set_max_entries(5'd0, '0);
    send_word(req(OP_PUSH, 32'h0000_0001));
  endtask

  task automatic test_lowered_limit();
    set_max_entries(5'd3, '0);
    send_word(req(OP_PUSH, 32'h0000_0011));
    send_word(req(OP_PUSH, 32'hffff_ff00));
    send_word(req(OP_PUSH, 32'h0000_0033));
    set_max_entries(5'd1, '0);
    send_word(req(OP_PUSH, 32'h0000_0044));
    send_word(req(OP_TOP, 32'h0));
    send_word(req(OP_POP, 32'h0));
  endtask

  task automatic test_random_traffic();
    logic [LIM_W-1:0] limits [7];
    int push_pct;
    int r;
    int ph;
    int n;
    logic [1:0] op;
    limits = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd20, 5'd5, 5'd10};
    for (ph = 0; ph < 7; ph++) begin
      if (ph == 6) limits[ph] = LIM_W'($urandom_range(0, 31));
      set_max_entries(limits[ph], (ph == 1) ? '1 : (PDATA_W-LIM_W)'($urandom));
      gaps_on = (ph != 0);
      push_pct = (ph % 2 == 0) ? 65 : 40;
      for (n = 0; n < 78; n++) begin
        if (ph == 3 && n == 39) wait_drained();
        r = $urandom_range(0, 99);
        if (r < push_pct) op = OP_PUSH;
        else if (r < push_pct + (100 - push_pct) / 2) op = OP_POP;
        else if (r < 95) op = OP_TOP;
        else op = OP_NOP;
        send_word(req(op, (op == OP_PUSH) ? pick_value() : $urandom));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    limit_writes = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    shadow_count = '0;
    shadow_max = MAX_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_extremes();
    test_limit_edges();
    test_lowered_limit();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests sent, %0d result words checked", words_sent, words_checked);
    $display("%0d limit settings written, incl. zero, one and above depth", limit_writes);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
